/* src/irps_pkg.sv */
// irps_pkg: shared types and constants for the ir remote pulse sequencer
// used by ir_remote_pulse_sequencer_unit; no dependencies
package irps_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DATA_W = 32;
  localparam int BITS_W = 6;
  localparam int DUR_W  = 15;
  localparam int STEP_W = 7;

  localparam logic [BITS_W-1:0] MAX_BITS         = 6'd32;
  localparam logic [DUR_W-1:0]  CANAL_LATENCY_US = 15'd40;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_TICK    = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PROTO_RC5   = 2'd0,
    PROTO_CANAL = 2'd1,
    PROTO_NEC   = 2'd2
  } proto_t;

  // configuration register indexes
  localparam logic [2:0] REG_RC5_HALF    = 3'd0;
  localparam logic [2:0] REG_CANAL_HALF  = 3'd1;
  localparam logic [2:0] REG_NEC_HDR_MK  = 3'd2;
  localparam logic [2:0] REG_NEC_HDR_SP  = 3'd3;
  localparam logic [2:0] REG_NEC_BIT_MK  = 3'd4;
  localparam logic [2:0] REG_NEC_ONE_SP  = 3'd5;
  localparam logic [2:0] REG_NEC_ZERO_SP = 3'd6;

  localparam logic [DUR_W-1:0] RST_RC5_HALF    = 15'd889;
  localparam logic [DUR_W-1:0] RST_CANAL_HALF  = 15'd500;
  localparam logic [DUR_W-1:0] RST_NEC_HDR_MK  = 15'd9000;
  localparam logic [DUR_W-1:0] RST_NEC_HDR_SP  = 15'd4500;
  localparam logic [DUR_W-1:0] RST_NEC_BIT_MK  = 15'd560;
  localparam logic [DUR_W-1:0] RST_NEC_ONE_SP  = 15'd1690;
  localparam logic [DUR_W-1:0] RST_NEC_ZERO_SP = 15'd560;

  // one queued command: left-justified data, bit count, protocol
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [BITS_W-1:0] bits;
    logic [1:0]        proto;
  } cmd_t;

endpackage

/* src/ir_remote_pulse_sequencer_unit.sv */
// ir_remote_pulse_sequencer_unit: command queue plus rc5 / canal / nec segment sequencer
// depends on irps_pkg
//
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_stall  operation, payload, bit_count, protocol
//  out_      output     out_valid/out_stall carrier_on, duration_us, frame_done, rejected
//  cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// each item that yields a segment has it computed from the sequencer
// registers and the queue head; it lands in the result register as the item is taken.
// the result register frees itself when taken, so one item per cycle sustains unless
// a result waits and out_stall holds it; in_stall is high only then.
// rst_n (synchronous) empties the queue, stops the frame and reloads the timings.
module ir_remote_pulse_sequencer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_operation,
  input  logic [31:0]                in_payload,
  input  logic [5:0]                 in_bit_count,
  input  logic [1:0]                 in_protocol,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_carrier_on,
  output logic [14:0]                out_duration_us,
  output logic                       out_frame_done,
  output logic                       out_rejected,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [14:0]                cfg_data
);

  localparam int QW = irps_pkg::QIDX_W;
  localparam int CW = irps_pkg::QCNT_W;
  localparam int DW = irps_pkg::DUR_W;
  localparam int SW = irps_pkg::STEP_W;

  // timing registers
  logic [DW-1:0] rc5_half_r, canal_half_r, nec_hdr_mk_r, nec_hdr_sp_r;
  logic [DW-1:0] nec_bit_mk_r, nec_one_sp_r, nec_zero_sp_r;

  // queue and sequencer state
  irps_pkg::cmd_t q_mem [irps_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt, wr_inc, rd_inc;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [31:0]    shift_r, shift_nxt;
  logic [SW-1:0]  step_r, step_nxt;
  logic           run_r, run_nxt;
  logic           lvl_r, lvl_nxt;
  logic [DW-1:0]  pend_r, pend_nxt;
  logic [5:0]     bits_r, bits_nxt;
  logic [1:0]     proto_r, proto_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic           out_lvl_r, out_done_r, out_rej_r;
  logic [DW-1:0]  out_dur_r;

  logic           in_xfer;
  logic           q_we;
  irps_pkg::cmd_t push_entry, start_entry;
  logic [5:0]     push_bits, push_sh;
  logic [1:0]     push_proto;

  logic           res_valid, res_rej;
  logic           do_seg, seg_start;

  logic [31:0]    seg_shift;
  logic [5:0]     seg_bits;
  logic [1:0]     seg_proto;
  logic [SW-1:0]  seg_step;
  logic [SW:0]    twice, twice_p2, step_x;
  logic           seg_lvl, seg_stop, seg_take, seg_pend_load;
  logic [DW-1:0]  seg_dur, canal_first;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_carrier_on  = out_lvl_r;
  assign out_duration_us = out_dur_r;
  assign out_frame_done  = out_done_r;
  assign out_rejected    = out_rej_r;

  assign wr_inc = (wr_r == QW'(irps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == QW'(irps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;

  // push normalization: saturate count and protocol, left-justify data
  always_comb begin
    push_bits  = (in_bit_count > irps_pkg::MAX_BITS) ? irps_pkg::MAX_BITS : in_bit_count;
    push_proto = (in_protocol == 2'd3) ? irps_pkg::PROTO_NEC : in_protocol;
    push_sh    = irps_pkg::MAX_BITS - push_bits;
    push_entry.data  = (push_bits == '0) ? '0 : (in_payload << push_sh[4:0]);
    push_entry.bits  = push_bits;
    push_entry.proto = push_proto;
  end

  // event decode and state update
  always_comb begin
    wr_nxt      = wr_r;
    rd_nxt      = rd_r;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    step_nxt    = step_r;
    run_nxt     = run_r;
    lvl_nxt     = lvl_r;
    pend_nxt    = pend_r;
    bits_nxt    = bits_r;
    proto_nxt   = proto_r;
    q_we        = 1'b0;
    res_valid   = 1'b0;
    res_rej     = 1'b0;
    do_seg      = 1'b0;
    seg_start   = 1'b0;
    start_entry = push_entry;

    if (in_xfer) begin
      unique case (in_operation)
        irps_pkg::OP_PUSH: begin
          if (cnt_r == CW'(irps_pkg::QUEUE_DEPTH)) begin
            res_valid = 1'b1;
            res_rej   = 1'b1;
          end else begin
            q_we    = 1'b1;
            wr_nxt  = wr_inc;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == '0) begin
              do_seg    = 1'b1;
              seg_start = 1'b1;
            end
          end
        end
        irps_pkg::OP_TICK: begin
          do_seg = run_r;
        end
        irps_pkg::OP_TIMEOUT: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
            rd_nxt  = rd_inc;
            run_nxt = 1'b0;
            if (cnt_r > CW'(1)) begin
              do_seg      = 1'b1;
              seg_start   = 1'b1;
              start_entry = q_mem[rd_inc];
            end
          end
        end
        default: ;
      endcase
    end

    if (do_seg) begin
      res_valid = 1'b1;
      bits_nxt  = seg_bits;
      proto_nxt = seg_proto;
      shift_nxt = seg_take ? {seg_shift[30:0], 1'b0} : seg_shift;
      step_nxt  = seg_step + 1'b1;
      lvl_nxt   = seg_stop ? 1'b0 : seg_lvl;
      run_nxt   = !seg_stop;
      if (seg_pend_load) begin
        pend_nxt = seg_shift[31] ? nec_one_sp_r : nec_zero_sp_r;
      end
    end
  end

  // segment generator: a new frame starts at step 0 from the queue head
  always_comb begin
    seg_shift = seg_start ? start_entry.data  : shift_r;
    seg_bits  = seg_start ? start_entry.bits  : bits_r;
    seg_proto = seg_start ? start_entry.proto : proto_r;
    seg_step  = seg_start ? '0 : step_r;

    twice    = {1'b0, seg_bits, 1'b0};
    twice_p2 = twice + (SW+1)'(2);
    step_x   = {1'b0, seg_step};
    canal_first = (canal_half_r > irps_pkg::CANAL_LATENCY_US) ?
                  canal_half_r - irps_pkg::CANAL_LATENCY_US : '0;

    seg_lvl       = lvl_r;
    seg_dur       = '0;
    seg_stop      = 1'b0;
    seg_take      = 1'b0;
    seg_pend_load = 1'b0;

    case (seg_proto)
      irps_pkg::PROTO_RC5: begin
        seg_dur = rc5_half_r;
        if (seg_step == '0) begin
          seg_lvl = 1'b1;
        end else if (seg_step[0]) begin
          if (step_x <= twice) begin
            seg_lvl  = !seg_shift[31];
            seg_take = 1'b1;
          end else begin
            seg_stop = 1'b1;
          end
        end else begin
          seg_lvl = !lvl_r;
        end
      end
      irps_pkg::PROTO_CANAL: begin
        seg_dur = canal_half_r;
        if (seg_step[0]) begin
          seg_lvl = !lvl_r;
        end else if (step_x < twice) begin
          seg_lvl  = seg_shift[31];
          seg_take = 1'b1;
          if (seg_step == '0) begin
            seg_dur = canal_first;
          end
        end else begin
          seg_stop = 1'b1;
        end
      end
      default: begin
        if (seg_step == '0) begin
          seg_lvl = 1'b1;
          seg_dur = nec_hdr_mk_r;
        end else if (seg_step == SW'(1)) begin
          seg_lvl = 1'b0;
          seg_dur = nec_hdr_sp_r;
        end else if (seg_step[0]) begin
          if (step_x > twice_p2) begin
            seg_stop = 1'b1;
          end else begin
            seg_lvl = 1'b0;
            seg_dur = pend_r;
          end
        end else begin
          seg_lvl = 1'b1;
          seg_dur = nec_bit_mk_r;
          // space for this bit is chosen with its mark, sent on the next step
          if (step_x < twice_p2) begin
            seg_take      = 1'b1;
            seg_pend_load = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[wr_r] <= push_entry;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_rej_r  <= res_rej;
      out_done_r <= !res_rej && seg_stop;
      out_lvl_r  <= !res_rej && !seg_stop && seg_lvl;
      out_dur_r  <= (res_rej || seg_stop) ? '0 : seg_dur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc5_half_r    <= irps_pkg::RST_RC5_HALF;
      canal_half_r  <= irps_pkg::RST_CANAL_HALF;
      nec_hdr_mk_r  <= irps_pkg::RST_NEC_HDR_MK;
      nec_hdr_sp_r  <= irps_pkg::RST_NEC_HDR_SP;
      nec_bit_mk_r  <= irps_pkg::RST_NEC_BIT_MK;
      nec_one_sp_r  <= irps_pkg::RST_NEC_ONE_SP;
      nec_zero_sp_r <= irps_pkg::RST_NEC_ZERO_SP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        irps_pkg::REG_RC5_HALF:    rc5_half_r    <= cfg_data;
        irps_pkg::REG_CANAL_HALF:  canal_half_r  <= cfg_data;
        irps_pkg::REG_NEC_HDR_MK:  nec_hdr_mk_r  <= cfg_data;
        irps_pkg::REG_NEC_HDR_SP:  nec_hdr_sp_r  <= cfg_data;
        irps_pkg::REG_NEC_BIT_MK:  nec_bit_mk_r  <= cfg_data;
        irps_pkg::REG_NEC_ONE_SP:  nec_one_sp_r  <= cfg_data;
        irps_pkg::REG_NEC_ZERO_SP: nec_zero_sp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= '0;
      rd_r        <= '0;
      cnt_r       <= '0;
      shift_r     <= '0;
      step_r      <= '0;
      run_r       <= 1'b0;
      lvl_r       <= 1'b0;
      pend_r      <= '0;
      bits_r      <= '0;
      proto_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      step_r      <= step_nxt;
      run_r       <= run_nxt;
      lvl_r       <= lvl_nxt;
      pend_r      <= pend_nxt;
      bits_r      <= bits_nxt;
      proto_r     <= proto_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for ir_remote_pulse_sequencer_unit (rc5 / canal / nec)
// depends on irps_pkg and the unit rtl; drives push / tick / timeout items and
// timing register writes, predicts every segment and checks it in order
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [1:0] PROTO_NEC_ALIAS = 2'd3;

  // timing register programming modes
  localparam int TM_RESET  = 0;
  localparam int TM_MAX    = 1;
  localparam int TM_ZERO   = 2;
  localparam int TM_ONE    = 3;
  localparam int TM_RANDOM = 4;

  typedef struct packed {
    logic                       carrier_on;
    logic [irps_pkg::DUR_W-1:0] duration_us;
    logic                       frame_done;
    logic                       rejected;
  } segment_t;

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        in_valid        = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_operation    = irps_pkg::OP_TICK;
  logic [irps_pkg::DATA_W-1:0] in_payload      = '0;
  logic [irps_pkg::BITS_W-1:0] in_bit_count    = '0;
  logic [1:0]                  in_protocol     = irps_pkg::PROTO_RC5;
  logic                        out_valid;
  logic                        out_stall       = 1'b0;
  logic                        out_carrier_on;
  logic [irps_pkg::DUR_W-1:0]  out_duration_us;
  logic                        out_frame_done;
  logic                        out_rejected;
  logic                        cfg_valid       = 1'b0;
  logic                        cfg_ready;
  logic [2:0]                  cfg_index       = irps_pkg::REG_RC5_HALF;
  logic [irps_pkg::DUR_W-1:0]  cfg_data        = '0;

  ir_remote_pulse_sequencer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_payload      (in_payload),
    .in_bit_count    (in_bit_count),
    .in_protocol     (in_protocol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_carrier_on  (out_carrier_on),
    .out_duration_us (out_duration_us),
    .out_frame_done  (out_frame_done),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // sequencer mirror
  logic [irps_pkg::DUR_W-1:0]  timing_us [0:6];
  irps_pkg::cmd_t              cmd_store [irps_pkg::QUEUE_DEPTH];
  int unsigned                 head_idx;
  int unsigned                 tail_idx;
  int unsigned                 cmd_count;
  logic [irps_pkg::DATA_W-1:0] bits_left;
  logic [irps_pkg::STEP_W-1:0] step_no;
  logic                        frame_on;
  logic                        carrier_level;
  logic [irps_pkg::DUR_W-1:0]  nec_space_us;
  logic [irps_pkg::BITS_W-1:0] frame_bits;
  logic [1:0]                  frame_proto;

  segment_t expected_segments [$];

  bit idle_enable = 1'b1;
  int stall_left = 0;
  int effective_items = 0;
  int segments_checked = 0;
  int frames_seen = 0;
  int rejects_seen = 0;
  int timing_settings = 0;
  int mismatch_count = 0;

  function automatic segment_t make_segment(input logic level,
                                            input logic [irps_pkg::DUR_W-1:0] dur,
                                            input logic done, input logic rej);
    segment_t s;
    s.carrier_on  = level;
    s.duration_us = dur;
    s.frame_done  = done;
    s.rejected    = rej;
    return s;
  endfunction

  function automatic logic [irps_pkg::DUR_W-1:0] reset_timing(input int r);
    case (r)
      irps_pkg::REG_RC5_HALF:   return irps_pkg::RST_RC5_HALF;
      irps_pkg::REG_CANAL_HALF: return irps_pkg::RST_CANAL_HALF;
      irps_pkg::REG_NEC_HDR_MK: return irps_pkg::RST_NEC_HDR_MK;
      irps_pkg::REG_NEC_HDR_SP: return irps_pkg::RST_NEC_HDR_SP;
      irps_pkg::REG_NEC_BIT_MK: return irps_pkg::RST_NEC_BIT_MK;
      irps_pkg::REG_NEC_ONE_SP: return irps_pkg::RST_NEC_ONE_SP;
      default:                  return irps_pkg::RST_NEC_ZERO_SP;
    endcase
  endfunction

  function automatic void reset_sequencer_mirror();
    for (int r = irps_pkg::REG_RC5_HALF; r <= irps_pkg::REG_NEC_ZERO_SP; r++)
      timing_us[r] = reset_timing(r);
    head_idx      = 0;
    tail_idx      = 0;
    cmd_count     = 0;
    bits_left     = '0;
    step_no       = '0;
    frame_on      = 1'b0;
    carrier_level = 1'b0;
    nec_space_us  = '0;
    frame_bits    = '0;
    frame_proto   = irps_pkg::PROTO_RC5;
  endfunction

  function automatic logic shift_out_bit();
    logic b;
    b = bits_left[irps_pkg::DATA_W-1];
    bits_left = bits_left << 1;
    return b;
  endfunction

  // next segment of the running frame; advances the step
  function automatic segment_t next_segment();
    int s;
    int twice;
    logic [irps_pkg::DUR_W-1:0] dur;
    logic stop;
    segment_t seg;
    s     = int'(step_no);
    twice = 2 * int'(frame_bits);
    dur   = '0;
    stop  = 1'b0;
    case (frame_proto)
      irps_pkg::PROTO_RC5: begin
        dur = timing_us[irps_pkg::REG_RC5_HALF];
        if (s == 0) carrier_level = 1'b1;
        else if (s % 2 == 1) begin
          if (s <= twice) carrier_level = ~shift_out_bit();
          else stop = 1'b1;
        end else carrier_level = ~carrier_level;
      end
      irps_pkg::PROTO_CANAL: begin
        dur = timing_us[irps_pkg::REG_CANAL_HALF];
        if (s % 2 == 1) carrier_level = ~carrier_level;
        else if (s < twice) begin
          carrier_level = shift_out_bit();
          // first half bit shortened, floored at zero
          if (s == 0)
            dur = (dur > irps_pkg::CANAL_LATENCY_US) ? dur - irps_pkg::CANAL_LATENCY_US : '0;
        end else stop = 1'b1;
      end
      default: begin
        if (s == 0) begin
          carrier_level = 1'b1;
          dur = timing_us[irps_pkg::REG_NEC_HDR_MK];
        end else if (s == 1) begin
          carrier_level = 1'b0;
          dur = timing_us[irps_pkg::REG_NEC_HDR_SP];
        end else if (s % 2 == 1) begin
          if (s - 2 > twice) stop = 1'b1;
          else begin
            carrier_level = 1'b0;
            dur = nec_space_us;
          end
        end else begin
          carrier_level = 1'b1;
          dur = timing_us[irps_pkg::REG_NEC_BIT_MK];
          if (s - 2 < twice)
            nec_space_us = shift_out_bit() ? timing_us[irps_pkg::REG_NEC_ONE_SP] :
                                             timing_us[irps_pkg::REG_NEC_ZERO_SP];
        end
      end
    endcase
    if (stop) begin
      carrier_level = 1'b0;
      frame_on = 1'b0;
      seg = make_segment(1'b0, '0, 1'b1, 1'b0);
    end else begin
      seg = make_segment(carrier_level, dur, 1'b0, 1'b0);
    end
    step_no = step_no + 1'b1;
    return seg;
  endfunction

  function automatic segment_t start_head_command();
    irps_pkg::cmd_t c;
    c = cmd_store[head_idx];
    bits_left   = c.data;
    frame_bits  = c.bits;
    frame_proto = c.proto;
    step_no     = '0;
    frame_on    = 1'b1;
    return next_segment();
  endfunction

  // updates the mirror for one accepted item and queues the segment it causes
  function automatic void predict_item(input logic [1:0] op,
                                       input logic [irps_pkg::DATA_W-1:0] data,
                                       input logic [irps_pkg::BITS_W-1:0] n,
                                       input logic [1:0] p,
                                       output bit effective);
    irps_pkg::cmd_t c;
    logic [irps_pkg::BITS_W-1:0] nb;
    effective = 1'b0;
    case (op)
      irps_pkg::OP_PUSH: begin
        effective = 1'b1;
        if (cmd_count >= irps_pkg::QUEUE_DEPTH) begin
          expected_segments.push_back(make_segment(1'b0, '0, 1'b0, 1'b1));
        end else begin
          nb = (n > irps_pkg::MAX_BITS) ? irps_pkg::MAX_BITS : n;
          c.data  = (nb == 0) ? '0 : data << (irps_pkg::DATA_W - nb);
          c.bits  = nb;
          c.proto = (p > irps_pkg::PROTO_NEC) ? irps_pkg::PROTO_NEC : p;
          cmd_store[tail_idx] = c;
          tail_idx = (tail_idx + 1) % irps_pkg::QUEUE_DEPTH;
          cmd_count++;
          if (cmd_count == 1) expected_segments.push_back(start_head_command());
        end
      end
      irps_pkg::OP_TICK: begin
        if (frame_on) begin
          effective = 1'b1;
          expected_segments.push_back(next_segment());
        end
      end
      irps_pkg::OP_TIMEOUT: begin
        if (cmd_count != 0) begin
          effective = 1'b1;
          cmd_count--;
          head_idx = (head_idx + 1) % irps_pkg::QUEUE_DEPTH;
          frame_on = 1'b0;
          if (cmd_count > 0) expected_segments.push_back(start_head_command());
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [irps_pkg::DATA_W-1:0] data,
                           input logic [irps_pkg::BITS_W-1:0] n, input logic [1:0] p);
    bit effective;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_payload   <= data;
    in_bit_count <= n;
    in_protocol  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(op, data, n, p, effective);
    if (effective) effective_items++;
  endtask

  task automatic send_tick();
    send_item(irps_pkg::OP_TICK, $urandom(), irps_pkg::BITS_W'($urandom()), 2'($urandom()));
  endtask

  task automatic send_timeout();
    send_item(irps_pkg::OP_TIMEOUT, $urandom(), irps_pkg::BITS_W'($urandom()),
              2'($urandom()));
  endtask

  task automatic random_push();
    int pick;
    logic [irps_pkg::BITS_W-1:0] n;
    logic [1:0] p;
    pick = $urandom_range(0, 19);
    if (pick < 14)      n = irps_pkg::BITS_W'($urandom_range(1, 8));
    else if (pick < 18) n = irps_pkg::BITS_W'($urandom_range(9, 32));
    else if (pick < 19) n = '0;
    else                n = irps_pkg::BITS_W'($urandom_range(33, 63));
    p = ($urandom_range(0, 9) == 0) ? PROTO_NEC_ALIAS : 2'($urandom_range(0, 2));
    send_item(irps_pkg::OP_PUSH, $urandom(), n, p);
  endtask

  // ticks until the stop segment, then retires the command; may cut the frame short
  task automatic play_frame(input int cut_chance);
    while (frame_on) begin
      if (cut_chance != 0 && $urandom_range(1, cut_chance) == 1) break;
      send_tick();
    end
    if (cut_chance != 0 && $urandom_range(0, 7) == 0) send_tick();
    send_timeout();
  endtask

  // sender holds off until every predicted segment has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_segments.size() != 0 || out_valid) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_timings(input int mode, input int canal_us);
    logic [irps_pkg::DUR_W-1:0] v;
    for (int r = irps_pkg::REG_RC5_HALF; r <= irps_pkg::REG_NEC_ZERO_SP; r++) begin
      case (mode)
        TM_MAX:   v = '1;
        TM_ZERO:  v = '0;
        TM_ONE:   v = irps_pkg::DUR_W'(1);
        TM_RESET: v = reset_timing(r);
        default:  v = ($urandom_range(0, 3) == 0) ? irps_pkg::DUR_W'($urandom()) :
                                                    irps_pkg::DUR_W'($urandom_range(0, 2000));
      endcase
      if (r == irps_pkg::REG_CANAL_HALF && canal_us >= 0) v = irps_pkg::DUR_W'(canal_us);
      cfg_valid <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data  <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      timing_us[r] = v;
    end
    cfg_valid <= 1'b0;
    timing_settings++;
  endtask

  task automatic test_directed_cases();
    send_tick();                                   // nothing running
    send_timeout();                                // queue empty
    send_item(OP_UNUSED, '1, '1, '1);
    send_item(irps_pkg::OP_PUSH, '0, '0, irps_pkg::PROTO_CANAL); // canal without data
    send_timeout();
    send_item(irps_pkg::OP_PUSH, '1, irps_pkg::BITS_W'(2), irps_pkg::PROTO_RC5);
    play_frame(0);
    send_item(irps_pkg::OP_PUSH, irps_pkg::DATA_W'(1), irps_pkg::BITS_W'(1),
              irps_pkg::PROTO_NEC);
    play_frame(0);
    send_item(irps_pkg::OP_PUSH, '0, '0, PROTO_NEC_ALIAS);   // preamble only
    play_frame(0);
  endtask

  // extremes of the timing registers, canal floor around the 40 us cut
  task automatic test_timing_settings();
    int canal_us;
    int mode;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin mode = TM_MAX;    canal_us = -1; end
        1: begin mode = TM_ZERO;   canal_us = -1; end
        2: begin mode = TM_ONE;    canal_us = 40; end
        3: begin mode = TM_RANDOM; canal_us = 39; end
        4: begin mode = TM_RANDOM; canal_us = 41; end
        5: begin mode = TM_MAX;    canal_us = 0;  end
        default: begin mode = TM_RANDOM; canal_us = -1; end
      endcase
      drain_results();
      program_timings(mode, canal_us);
      for (int p = irps_pkg::PROTO_RC5; p <= irps_pkg::PROTO_NEC; p++) begin
        send_item(irps_pkg::OP_PUSH, $urandom(), irps_pkg::BITS_W'($urandom_range(1, 4)),
                  2'(p));
        play_frame(0);
      end
    end
  endtask

  task automatic test_random_traffic(input int target);
    int start;
    int pick;
    start = effective_items;
    while (effective_items - start < target) begin
      pick = $urandom_range(0, 39);
      if (pick < 28) begin
        repeat ($urandom_range(1, 3)) random_push();
        while (cmd_count != 0) play_frame(60);
      end else if (pick < 34) begin
        // overfill the queue while a frame runs
        repeat ($urandom_range(4, 12)) random_push();
      end else if (pick < 39) begin
        repeat ($urandom_range(1, 8))
          send_item(2'($urandom_range(0, 3)), $urandom(),
                    irps_pkg::BITS_W'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
      end else begin
        drain_results();
      end
    end
  endtask

  task automatic test_back_to_back(input int target);
    drain_results();
    program_timings(TM_RESET, -1);
    idle_enable = 1'b0;
    test_random_traffic(target);
  endtask

  task automatic note_mismatch(input string what, input bit has_want, input segment_t want,
                               input segment_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      if (has_want)
        $display("%s at %0t: expected %0b/%0d/%0b/%0b got %0b/%0d/%0b/%0b",
                 what, $realtime, want.carrier_on, want.duration_us, want.frame_done,
                 want.rejected, got.carrier_on, got.duration_us, got.frame_done, got.rejected);
      else
        $display("%s at %0t: got carrier %0b dur %0d done %0b rej %0b", what, $realtime,
                 got.carrier_on, got.duration_us, got.frame_done, got.rejected);
    end
  endtask

  always @(posedge clk) begin : check_segments
    segment_t got;
    segment_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = make_segment(out_carrier_on, out_duration_us, out_frame_done, out_rejected);
      if (expected_segments.size() == 0) begin
        note_mismatch("unexpected segment", 1'b0, got, got);
      end else begin
        want = expected_segments.pop_front();
        segments_checked++;
        if (got.carrier_on !== want.carrier_on || got.duration_us !== want.duration_us ||
            got.frame_done !== want.frame_done || got.rejected !== want.rejected)
          note_mismatch("segment mismatch", 1'b1, want, got);
      end
      if (got.rejected === 1'b1) rejects_seen++;
      if (got.frame_done === 1'b1) frames_seen++;
    end
  end

  // random stall bursts on the result side
  always @(posedge clk) begin
    if (!idle_enable) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    reset_sequencer_mirror();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_timing_settings();
    test_random_traffic(1000);
    test_back_to_back(300);
    drain_results();

    if (expected_segments.size() != 0) begin
      mismatch_count += expected_segments.size();
      $display("%0d expected segments never arrived", expected_segments.size());
    end
    $display("checked %0d segments: %0d frame ends, %0d full-queue rejects",
             segments_checked, frames_seen, rejects_seen);
    $display("%0d state-changing items over %0d timing register settings",
             effective_items, timing_settings);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
